[sv/fpr_pkg.sv]
// ----------------------------------------------------------------------------
// fpr_pkg - firmware packet receiver shared definitions
// Command and result codes, register indexes and the front-to-back queue entry.
// ----------------------------------------------------------------------------
package fpr_pkg;

	localparam int MAX_PAYLOAD_DEF = 128;
	localparam int WRITE_BYTES_DEF = 8;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_STAGING_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PACKET_MAGIC = 2'd1;

	localparam logic [1:0] CMD_START   = 2'd0;
	localparam logic [1:0] CMD_HEADER  = 2'd1;
	localparam logic [1:0] CMD_PAYLOAD = 2'd2;
	localparam logic [1:0] CMD_FINISH  = 2'd3;

	localparam logic [2:0] KIND_WRITE = 3'd0;
	localparam logic [2:0] KIND_ACK   = 3'd1;
	localparam logic [2:0] KIND_NACK  = 3'd2;
	localparam logic [2:0] KIND_ERROR = 3'd3;
	localparam logic [2:0] KIND_DONE  = 3'd4;

	localparam logic [1:0] REASON_NONE      = 2'd0;
	localparam logic [1:0] REASON_MAGIC     = 2'd1;
	localparam logic [1:0] REASON_SEQUENCE  = 2'd2;
	localparam logic [1:0] REASON_CRC       = 2'd3;

	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'hA001;
	localparam logic [15:0] MAGIC_RESET = 16'hAA55;

	localparam logic OP_SINGLE = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	typedef struct packed {
		logic        op;
		logic [2:0]  kind;
		logic [1:0]  reason;
		logic [15:0] pnum;
		logic [31:0] total;
		logic [31:0] addr;
		logic [7:0]  len;
	} queue_entry_t;

	typedef struct packed {
		logic flush_done;
	} back_status_t;

endpackage

[sv/fpr_ram.sv]
// ----------------------------------------------------------------------------
// fpr_ram - generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[sv/fpr_queue.sv]
// ----------------------------------------------------------------------------
// fpr_queue - short queue between front and back
// Holds classified work so that front and back stall independently.
// ----------------------------------------------------------------------------
module fpr_queue #(
	parameter int DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  fpr_pkg::queue_entry_t push_entry,
	output logic                 full,
	input  logic                 pop,
	output fpr_pkg::queue_entry_t pop_entry,
	output logic                 empty
);
	import fpr_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	queue_entry_t    slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign pop_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_q + 1'b1);
			end
			if (pop && !empty) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_q + 1'b1);
			end
			unique case ({push && !full, pop && !empty})
				2'b10:   count_q <= CW'(count_q + 1'b1);
				2'b01:   count_q <= CW'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[sv/fpr_front.sv]
// ----------------------------------------------------------------------------
// fpr_front - input side of the packet receiver
// Holds configuration and image state, checks headers, buffers payload bytes,
// runs the CRC-16 and queues one work entry per item that has results.
// ----------------------------------------------------------------------------
module fpr_front #(
	parameter int MAX_PAYLOAD = fpr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fpr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     cmd,
	input  logic [15:0]                    header_magic,
	input  logic [15:0]                    sequence_number,
	input  logic [7:0]                     payload_length,
	input  logic [15:0]                    header_crc,
	input  logic [7:0]                     data_byte,
	output logic                           q_push,
	output fpr_pkg::queue_entry_t          q_entry,
	input  logic                           q_full,
	input  fpr_pkg::back_status_t          back_status,
	output logic                           buf_wr_en,
	output logic [$clog2(MAX_PAYLOAD)-1:0] buf_wr_addr,
	output logic [7:0]                     buf_wr_data
);
	import fpr_pkg::*;

	localparam int AW = $clog2(MAX_PAYLOAD);
	localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

	localparam logic [1:0] MODE_IDLE    = 2'd0;
	localparam logic [1:0] MODE_HEADER  = 2'd1;
	localparam logic [1:0] MODE_PAYLOAD = 2'd2;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	logic [31:0] staging_base_q;
	logic [15:0] packet_magic_q;
	logic [1:0]  mode_q;
	logic [15:0] exp_seq_q;
	logic [31:0] next_addr_q;
	logic [31:0] byte_total_q;
	logic [15:0] crc_q;
	logic [15:0] exp_crc_q;
	logic [7:0]  pending_q;
	logic [7:0]  received_q;
	logic        flush_pend_q;

	logic        accept;
	logic [15:0] crc_new;
	logic [7:0]  received_new;
	logic        is_header;
	logic        is_byte;
	logic        is_finish;
	logic        hdr_bad_magic;
	logic        hdr_bad_seq;
	logic        hdr_empty;
	logic        pkt_end;
	logic        pkt_crc_ok;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full || flush_pend_q;
	assign accept    = in_valid && !in_stall;

	assign crc_new       = crc16_byte(crc_q, data_byte);
	assign received_new  = 8'(received_q + 8'd1);
	assign is_header     = accept && (cmd == CMD_HEADER) && (mode_q == MODE_HEADER);
	assign is_byte       = accept && (cmd == CMD_PAYLOAD) && (mode_q == MODE_PAYLOAD);
	assign is_finish     = accept && (cmd == CMD_FINISH) && (mode_q == MODE_HEADER);
	assign hdr_bad_magic = header_magic != packet_magic_q;
	assign hdr_bad_seq   = (sequence_number != exp_seq_q) || (payload_length > MAX_LEN);
	assign hdr_empty     = is_header && !hdr_bad_magic && !hdr_bad_seq
		&& (payload_length == 8'd0);
	assign pkt_end       = hdr_empty || (is_byte && (received_new >= pending_q));
	assign pkt_crc_ok    = hdr_empty ? (header_crc == CRC_INIT) : (crc_new == exp_crc_q);

	assign buf_wr_en   = is_byte;
	assign buf_wr_addr = received_q[AW-1:0];
	assign buf_wr_data = data_byte;

	always_comb begin
		q_push  = 1'b0;
		q_entry = '0;
		if (is_header && hdr_bad_magic) begin
			q_push         = 1'b1;
			q_entry.op     = OP_SINGLE;
			q_entry.kind   = KIND_ERROR;
			q_entry.reason = REASON_MAGIC;
			q_entry.pnum   = exp_seq_q;
		end else if (is_header && hdr_bad_seq) begin
			q_push         = 1'b1;
			q_entry.op     = OP_SINGLE;
			q_entry.kind   = KIND_NACK;
			q_entry.reason = REASON_SEQUENCE;
			q_entry.pnum   = sequence_number;
		end else if (pkt_end && !pkt_crc_ok) begin
			q_push         = 1'b1;
			q_entry.op     = OP_SINGLE;
			q_entry.kind   = KIND_NACK;
			q_entry.reason = REASON_CRC;
			q_entry.pnum   = exp_seq_q;
		end else if (pkt_end) begin
			q_push       = 1'b1;
			q_entry.op   = OP_FLUSH;
			q_entry.kind = KIND_ACK;
			q_entry.pnum = exp_seq_q;
			q_entry.addr = next_addr_q;
			q_entry.len  = hdr_empty ? 8'd0 : pending_q;
		end else if (is_finish) begin
			q_push        = 1'b1;
			q_entry.op    = OP_SINGLE;
			q_entry.kind  = KIND_DONE;
			q_entry.pnum  = exp_seq_q;
			q_entry.total = byte_total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			staging_base_q <= '0;
			packet_magic_q <= MAGIC_RESET;
			mode_q         <= MODE_IDLE;
			exp_seq_q      <= '0;
			next_addr_q    <= '0;
			byte_total_q   <= '0;
			crc_q          <= CRC_INIT;
			exp_crc_q      <= '0;
			pending_q      <= '0;
			received_q     <= '0;
			flush_pend_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_STAGING_BASE) begin
					staging_base_q <= cfg_data;
				end else if (cfg_index == REG_PACKET_MAGIC) begin
					packet_magic_q <= cfg_data[15:0];
				end
			end

			if (back_status.flush_done) begin
				flush_pend_q <= 1'b0;
			end

			if (accept && cmd == CMD_START) begin
				mode_q       <= MODE_HEADER;
				exp_seq_q    <= '0;
				next_addr_q  <= staging_base_q;
				byte_total_q <= '0;
				crc_q        <= CRC_INIT;
				exp_crc_q    <= '0;
				pending_q    <= '0;
				received_q   <= '0;
			end else if (is_header) begin
				if (hdr_bad_magic || hdr_bad_seq) begin
					mode_q <= MODE_IDLE;
				end else begin
					exp_crc_q  <= header_crc;
					pending_q  <= payload_length;
					received_q <= '0;
					crc_q      <= CRC_INIT;
					if (!hdr_empty) begin
						mode_q <= MODE_PAYLOAD;
					end
				end
			end else if (is_byte) begin
				crc_q      <= crc_new;
				received_q <= received_new;
			end else if (is_finish) begin
				mode_q <= MODE_IDLE;
			end

			if (pkt_end) begin
				if (pkt_crc_ok) begin
					mode_q       <= MODE_HEADER;
					exp_seq_q    <= 16'(exp_seq_q + 16'd1);
					next_addr_q  <= 32'(next_addr_q + {24'd0, hdr_empty ? 8'd0 : pending_q});
					byte_total_q <= 32'(byte_total_q + {24'd0, hdr_empty ? 8'd0 : pending_q});
					flush_pend_q <= 1'b1;
				end else begin
					mode_q <= MODE_IDLE;
				end
			end
		end
	end

endmodule

[sv/fpr_back.sv]
// ----------------------------------------------------------------------------
// fpr_back - result side of the packet receiver
// Takes queued work, reads buffered payload back, packs staging writes and
// drives the registered result channel.
// ----------------------------------------------------------------------------
module fpr_back #(
	parameter int MAX_PAYLOAD = fpr_pkg::MAX_PAYLOAD_DEF,
	parameter int WRITE_BYTES = fpr_pkg::WRITE_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  fpr_pkg::queue_entry_t          q_entry,
	input  logic                           q_empty,
	output logic                           q_pop,
	output fpr_pkg::back_status_t          back_status,
	output logic                           buf_rd_en,
	output logic [$clog2(MAX_PAYLOAD)-1:0] buf_rd_addr,
	input  logic [7:0]                     buf_rd_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [2:0]                     kind,
	output logic [1:0]                     reason,
	output logic [31:0]                    write_address,
	output logic [63:0]                    write_data,
	output logic [3:0]                     write_count,
	output logic [15:0]                    packet_number,
	output logic [31:0]                    image_bytes,
	output logic                           last
);
	import fpr_pkg::*;

	localparam int AW = $clog2(MAX_PAYLOAD);
	localparam int CW = $clog2(WRITE_BYTES + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_CAP  = 3'd2;
	localparam logic [2:0] ST_WR   = 3'd3;
	localparam logic [2:0] ST_ACK  = 3'd4;

	logic [2:0]  st_q;
	logic [7:0]  pos_q;
	logic [7:0]  len_q;
	logic [CW-1:0] bidx_q;
	logic [63:0] word_q;
	logic [31:0] addr_q;
	logic [15:0] pnum_q;
	logic        out_valid_q;
	logic        out_free;

	assign out_free    = !out_valid_q || !out_stall;
	assign out_valid   = out_valid_q;
	assign q_pop       = (st_q == ST_IDLE) && !q_empty && out_free;
	assign buf_rd_en   = (st_q == ST_RD);
	assign buf_rd_addr = pos_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (q_pop && q_entry.op == OP_SINGLE) begin
			kind          <= q_entry.kind;
			reason        <= q_entry.reason;
			write_address <= '0;
			write_data    <= '0;
			write_count   <= '0;
			packet_number <= q_entry.pnum;
			image_bytes   <= q_entry.total;
			last          <= 1'b1;
		end else if (st_q == ST_WR && out_free) begin
			kind          <= KIND_WRITE;
			reason        <= REASON_NONE;
			write_address <= addr_q;
			write_data    <= word_q;
			write_count   <= 4'(bidx_q);
			packet_number <= '0;
			image_bytes   <= '0;
			last          <= 1'b0;
		end else if (st_q == ST_ACK && out_free) begin
			kind          <= KIND_ACK;
			reason        <= REASON_NONE;
			write_address <= '0;
			write_data    <= '0;
			write_count   <= '0;
			packet_number <= pnum_q;
			image_bytes   <= '0;
			last          <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q                   <= ST_IDLE;
			pos_q                  <= '0;
			len_q                  <= '0;
			bidx_q                 <= '0;
			word_q                 <= '0;
			addr_q                 <= '0;
			pnum_q                 <= '0;
			out_valid_q            <= 1'b0;
			back_status.flush_done <= 1'b0;
		end else begin
			back_status.flush_done <= 1'b0;
			if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (q_pop) begin
						if (q_entry.op == OP_SINGLE) begin
							out_valid_q <= 1'b1;
						end else begin
							addr_q <= q_entry.addr;
							len_q  <= q_entry.len;
							pnum_q <= q_entry.pnum;
							pos_q  <= '0;
							bidx_q <= '0;
							word_q <= '0;
							st_q   <= (q_entry.len == 8'd0) ? ST_ACK : ST_RD;
						end
					end
				end
				ST_RD: begin
					st_q <= ST_CAP;
				end
				ST_CAP: begin
					for (int l = 0; l < WRITE_BYTES; l++) begin
						if (bidx_q == CW'(l)) begin
							word_q[8*l +: 8] <= buf_rd_data;
						end
					end
					pos_q  <= 8'(pos_q + 8'd1);
					bidx_q <= CW'(bidx_q + 1'b1);
					if (bidx_q == CW'(WRITE_BYTES - 1) || 8'(pos_q + 8'd1) == len_q) begin
						st_q <= ST_WR;
					end else begin
						st_q <= ST_RD;
					end
				end
				ST_WR: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						addr_q      <= 32'(addr_q + 32'(bidx_q));
						bidx_q      <= '0;
						word_q      <= '0;
						st_q        <= (pos_q == len_q) ? ST_ACK : ST_RD;
					end
				end
				ST_ACK: begin
					if (out_free) begin
						out_valid_q            <= 1'b1;
						back_status.flush_done <= 1'b1;
						st_q                   <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[sv/firmware_packet_receiver_core.sv]
// ----------------------------------------------------------------------------
// firmware_packet_receiver_core - firmware image packet receiver
// Checks packet headers, buffers payload under a CRC-16/MODBUS check and
// releases staging writes, acks, nacks, error halts and a done summary.
// ----------------------------------------------------------------------------
// channel  handshake              payload
// in       in_valid / in_stall    cmd, header_magic, sequence_number,
//                                 payload_length, header_crc, data_byte
// out      out_valid / out_stall  kind, reason, write_address, write_data,
//                                 write_count, packet_number, image_bytes, last
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The front checks headers and steps the CRC for each accepted transaction.
// The back pops a good packet's entry, reads and captures each payload byte
// (buffer read, capture), then registers each write and the ack as out_stall
// allows. in_stall is high while the two-entry queue is full and from the
// cycle after a good packet ends until the cycle after its ack is registered.
// cfg_ready is always high; the payload buffer needs no clearing after reset.
// ----------------------------------------------------------------------------
module firmware_packet_receiver_core #(
	parameter int MAX_PAYLOAD = fpr_pkg::MAX_PAYLOAD_DEF,
	parameter int WRITE_BYTES = fpr_pkg::WRITE_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fpr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    cmd,
	input  logic [15:0]                   header_magic,
	input  logic [15:0]                   sequence_number,
	input  logic [7:0]                    payload_length,
	input  logic [15:0]                   header_crc,
	input  logic [7:0]                    data_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    kind,
	output logic [1:0]                    reason,
	output logic [31:0]                   write_address,
	output logic [63:0]                   write_data,
	output logic [3:0]                    write_count,
	output logic [15:0]                   packet_number,
	output logic [31:0]                   image_bytes,
	output logic                          last
);
	import fpr_pkg::*;

	localparam int AW = $clog2(MAX_PAYLOAD);

	queue_entry_t  push_entry;
	queue_entry_t  pop_entry;
	back_status_t  back_status;
	logic          q_push;
	logic          q_full;
	logic          q_pop;
	logic          q_empty;
	logic          buf_wr_en;
	logic [AW-1:0] buf_wr_addr;
	logic [7:0]    buf_wr_data;
	logic          buf_rd_en;
	logic [AW-1:0] buf_rd_addr;
	logic [7:0]    buf_rd_data;

	fpr_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.header_magic   (header_magic),
		.sequence_number(sequence_number),
		.payload_length (payload_length),
		.header_crc     (header_crc),
		.data_byte      (data_byte),
		.q_push         (q_push),
		.q_entry        (push_entry),
		.q_full         (q_full),
		.back_status    (back_status),
		.buf_wr_en      (buf_wr_en),
		.buf_wr_addr    (buf_wr_addr),
		.buf_wr_data    (buf_wr_data)
	);

	fpr_queue #(
		.DEPTH(2)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_entry(push_entry),
		.full      (q_full),
		.pop       (q_pop),
		.pop_entry (pop_entry),
		.empty     (q_empty)
	);

	fpr_ram #(
		.WIDTH(8),
		.DEPTH(MAX_PAYLOAD)
	) u_buf (
		.clk    (clk),
		.wr_en  (buf_wr_en),
		.wr_addr(buf_wr_addr),
		.wr_data(buf_wr_data),
		.rd_en  (buf_rd_en),
		.rd_addr(buf_rd_addr),
		.rd_data(buf_rd_data)
	);

	fpr_back #(
		.MAX_PAYLOAD(MAX_PAYLOAD),
		.WRITE_BYTES(WRITE_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_entry      (pop_entry),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.back_status  (back_status),
		.buf_rd_en    (buf_rd_en),
		.buf_rd_addr  (buf_rd_addr),
		.buf_rd_data  (buf_rd_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.reason       (reason),
		.write_address(write_address),
		.write_data   (write_data),
		.write_count  (write_count),
		.packet_number(packet_number),
		.image_bytes  (image_bytes),
		.last         (last)
	);

endmodule
